FILE: src/y86ie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86ie_pkg
// Shared types and constants of the Y86-64 instruction execute core.
// ----------------------------------------------------------------------------
package y86ie_pkg;

	localparam int unsigned MemBytesDefault = 8192;
	localparam int unsigned WordBytes       = 8;
	localparam int unsigned RegCount        = 15;
	localparam logic [3:0]  RegRsp          = 4'd4;
	localparam logic [3:0]  RegNone         = 4'd15;

	typedef enum logic [3:0] {
		OP_HALT  = 4'd0,
		OP_NOP   = 4'd1,
		OP_CMOV  = 4'd2,
		OP_IRMOV = 4'd3,
		OP_RMMOV = 4'd4,
		OP_MRMOV = 4'd5,
		OP_ALU   = 4'd6,
		OP_JUMP  = 4'd7,
		OP_CALL  = 4'd8,
		OP_RET   = 4'd9,
		OP_PUSH  = 4'd10,
		OP_POP   = 4'd11,
		OP_IADD  = 4'd12
	} opcode_t;

	typedef enum logic [1:0] {
		ST_AOK = 2'd0,
		ST_HLT = 2'd1,
		ST_ADR = 2'd2,
		ST_INS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_AND = 2'd2,
		ALU_XOR = 2'd3
	} alu_fn_t;

	localparam logic [3:0] FN_ALWAYS = 4'd0;
	localparam logic [3:0] FN_LE     = 4'd1;
	localparam logic [3:0] FN_L      = 4'd2;
	localparam logic [3:0] FN_E      = 4'd3;
	localparam logic [3:0] FN_NE     = 4'd4;
	localparam logic [3:0] FN_GE     = 4'd5;
	localparam logic [3:0] FN_G      = 4'd6;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_READ,
		S_ALU,
		S_MEM,
		S_LOAD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic zf;
		logic sf;
		logic of;
	} flags_t;

	function automatic logic cond_eval(input logic [3:0] fn, input flags_t f);
		logic lt;
		lt = f.sf ^ f.of;
		unique case (fn)
			FN_ALWAYS: return 1'b1;
			FN_LE:     return lt | f.zf;
			FN_L:      return lt;
			FN_E:      return f.zf;
			FN_NE:     return ~f.zf;
			FN_GE:     return ~lt;
			FN_G:      return ~lt & ~f.zf;
			default:   return 1'b0;
		endcase
	endfunction

endpackage

FILE: src/y86_instruction_execute_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86_instruction_execute_core
// Executes one decoded Y86-64 instruction per request.
//
// channel   direction  handshake        payload
// request   in         start & !busy    mode func reg_a reg_b imm fallthrough_pc
// result    out        done (1 cycle)   next_pc status write_value flags
//
// A request steps through S_READ, S_ALU and S_DONE, with S_MEM (and S_LOAD
// for loads) between for a memory word access: the data memory moves one
// 64-bit row per cycle and an unaligned word spans two rows. After reset,
// busy stays high while the memory is cleared one row per cycle.
// The receiver cannot stall; done pulses for one cycle.
// ----------------------------------------------------------------------------
module y86_instruction_execute_core #(
	parameter int unsigned MEM_BYTES = y86ie_pkg::MemBytesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  mode,
	input  logic [3:0]  func,
	input  logic [3:0]  reg_a,
	input  logic [3:0]  reg_b,
	input  logic [63:0] imm,
	input  logic [15:0] fallthrough_pc,
	output logic        done,
	output logic [15:0] next_pc,
	output logic [1:0]  status,
	output logic [63:0] write_value,
	output logic [2:0]  flags
);
	import y86ie_pkg::*;

	localparam int unsigned ROWS = MEM_BYTES / WordBytes;
	localparam int unsigned RW   = $clog2(ROWS);

	state_t state_q, state_d;

	logic [63:0] regs_q [RegCount];
	flags_t      flg_q;
	status_t     run_q;

	logic [3:0]  mode_q, func_q, ra_q, rb_q;
	logic [63:0] imm_q;
	logic [15:0] fpc_q;
	logic [63:0] a_q, b_q, sp_q, res_q, addr_q, ld_lo_q;
	logic        phase_q;
	logic [RW-1:0] clr_q;

	logic [15:0] npc_q;
	logic [1:0]  st_q;
	logic [63:0] wv_q;
	logic        done_q;

	// ALU operand selection
	logic [63:0] alu_a, alu_b, alu_r;
	alu_fn_t     alu_fn;
	logic        alu_ovf;

	always_comb begin
		alu_a  = a_q;
		alu_b  = b_q;
		alu_fn = ALU_ADD;
		unique case (opcode_t'(mode_q))
			OP_ALU:              alu_fn = alu_fn_t'(func_q[1:0]);
			OP_RMMOV, OP_MRMOV,
			OP_IADD:             alu_a = imm_q;
			OP_CALL, OP_PUSH: begin
				alu_a = 64'(WordBytes);
				alu_b = sp_q;
				alu_fn = ALU_SUB;
			end
			OP_RET, OP_POP: begin
				alu_a = 64'(WordBytes);
				alu_b = sp_q;
			end
			default: ;
		endcase
	end

	y86ie_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.fn  (alu_fn),
		.r   (alu_r),
		.ovf (alu_ovf)
	);

	// memory port
	logic          mem_we;
	logic [RW-1:0] mem_waddr, mem_raddr;
	logic [63:0]   mem_wdata, mem_rdata, st_word;
	logic [7:0]    mem_wmask;
	logic [2:0]    boff;
	logic [RW-1:0] row0;
	logic [127:0]  st_wide, ld_wide;
	logic [15:0]   st_mask_wide;

	assign boff  = addr_q[2:0];
	assign row0  = addr_q[RW+2:3];
	assign st_word = (opcode_t'(mode_q) == OP_CALL) ? 64'(fpc_q) : a_q;
	assign st_wide = {64'd0, st_word} << {boff, 3'd0};
	assign st_mask_wide = 16'h00ff << boff;
	assign ld_wide = {mem_rdata, ld_lo_q} >> {boff, 3'd0};

	logic is_store, is_load, addr_ok;
	assign is_store = (opcode_t'(mode_q) == OP_RMMOV) || (opcode_t'(mode_q) == OP_CALL)
		|| (opcode_t'(mode_q) == OP_PUSH);
	assign is_load = (opcode_t'(mode_q) == OP_MRMOV) || (opcode_t'(mode_q) == OP_RET)
		|| (opcode_t'(mode_q) == OP_POP);
	assign addr_ok = addr_q <= 64'(MEM_BYTES - WordBytes);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = row0 + RW'(phase_q);
		mem_wdata = phase_q ? st_wide[127:64] : st_wide[63:0];
		mem_wmask = phase_q ? st_mask_wide[15:8] : st_mask_wide[7:0];
		mem_raddr = row0 + RW'(phase_q);
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
			mem_wmask = '1;
		end else if (state_q == S_MEM && is_store) begin
			mem_we = 1'b1;
		end
	end

	y86ie_dmem #(.ROWS(ROWS)) u_dmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.wmask (mem_wmask),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sequencer
	logic [3:0] fn_ok_lim;
	logic       bad, cond_ok;
	assign cond_ok = cond_eval(func_q, flg_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == RW'(ROWS - 1)) state_d = S_IDLE;
			S_IDLE:  if (start) state_d = S_READ;
			S_READ:  state_d = S_ALU;
			S_ALU: begin
				if (run_q != ST_AOK) state_d = S_DONE;
				else if (is_store || is_load) state_d = S_MEM;
				else state_d = S_DONE;
			end
			S_MEM: begin
				if (!addr_ok) state_d = S_DONE;
				else if (phase_q && is_load) state_d = S_LOAD;
				else if (phase_q) state_d = S_DONE;
				else if (boff == 3'd0 && is_store) state_d = S_DONE;
			end
			S_LOAD:  state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end
	assign fn_ok_lim = 4'd6;
	assign bad = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			run_q   <= ST_AOK;
			flg_q   <= '{zf: 1'b1, sf: 1'b0, of: 1'b0};
			for (int i = 0; i < RegCount; i++) regs_q[i] <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			unique case (state_q)
				S_CLEAR: clr_q <= clr_q + RW'(1);
				S_IDLE: begin
					mode_q <= mode;
					func_q <= func;
					ra_q   <= reg_a;
					rb_q   <= reg_b;
					imm_q  <= imm;
					fpc_q  <= fallthrough_pc;
				end
				S_READ: begin
					a_q   <= (ra_q == RegNone) ? 64'd0 : regs_q[ra_q];
					b_q   <= (rb_q == RegNone) ? 64'd0 : regs_q[rb_q];
					sp_q  <= regs_q[RegRsp];
					npc_q <= fpc_q;
					wv_q  <= '0;
					phase_q <= 1'b0;
				end
				S_ALU: begin
					res_q <= alu_r;
					unique case (opcode_t'(mode_q))
						OP_RET, OP_POP: addr_q <= sp_q;
						default:        addr_q <= alu_r;
					endcase
					if (run_q == ST_AOK) begin
						unique case (opcode_t'(mode_q))
							OP_HALT: run_q <= ST_HLT;
							OP_NOP: ;
							OP_CMOV: begin
								if (func_q > fn_ok_lim || bad) run_q <= ST_INS;
								else if (cond_ok) begin
									if (rb_q != RegNone) regs_q[rb_q] <= a_q;
									wv_q <= a_q;
								end
							end
							OP_IRMOV: begin
								if (rb_q != RegNone) regs_q[rb_q] <= imm_q;
								wv_q <= imm_q;
							end
							OP_ALU, OP_IADD: begin
								if (opcode_t'(mode_q) == OP_ALU && func_q > 4'd3) begin
									run_q <= ST_INS;
								end else begin
									flg_q <= '{zf: alu_r == 64'd0, sf: alu_r[63], of: alu_ovf};
									if (rb_q != RegNone) regs_q[rb_q] <= alu_r;
									wv_q <= alu_r;
								end
							end
							OP_JUMP: begin
								if (func_q > fn_ok_lim) run_q <= ST_INS;
								else if (cond_ok) npc_q <= imm_q[15:0];
							end
							OP_RMMOV, OP_MRMOV, OP_CALL, OP_RET, OP_PUSH, OP_POP: ;
							default: run_q <= ST_INS;
						endcase
					end
				end
				S_MEM: begin
					phase_q <= 1'b1;
					ld_lo_q <= mem_rdata;
					if (!addr_ok) begin
						run_q <= ST_ADR;
					end else if (is_store && (phase_q || boff == 3'd0)) begin
						if (opcode_t'(mode_q) != OP_RMMOV) regs_q[RegRsp] <= res_q;
						wv_q <= st_word;
						if (opcode_t'(mode_q) == OP_CALL) npc_q <= imm_q[15:0];
					end
				end
				S_LOAD: begin
					unique case (opcode_t'(mode_q))
						OP_MRMOV: begin
							if (ra_q != RegNone) regs_q[ra_q] <= ld_wide[63:0];
							wv_q <= ld_wide[63:0];
						end
						OP_POP: begin
							regs_q[RegRsp] <= (ra_q == RegRsp) ? ld_wide[63:0] : res_q;
							if (ra_q != RegNone && ra_q != RegRsp)
								regs_q[ra_q] <= ld_wide[63:0];
							wv_q <= ld_wide[63:0];
						end
						default: begin
							regs_q[RegRsp] <= res_q;
							wv_q  <= res_q;
							npc_q <= ld_wide[15:0];
						end
					endcase
				end
				S_DONE: begin
					done_q <= 1'b1;
					st_q   <= run_q;
					if (run_q == ST_ADR || run_q == ST_INS) begin
						npc_q <= fpc_q;
						wv_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// an aligned load holds the low row in ld_lo_q after the second read
	// phase, so the load word is only complete in S_LOAD

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign next_pc     = npc_q;
	assign status      = st_q;
	assign write_value = wv_q;
	assign flags       = {flg_q.zf, flg_q.sf, flg_q.of};

endmodule

FILE: src/y86ie_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86ie_alu
// Shared 64-bit ALU: add and subtract with overflow, and, xor.
// ----------------------------------------------------------------------------
module y86ie_alu (
	input  logic [63:0]           a,
	input  logic [63:0]           b,
	input  y86ie_pkg::alu_fn_t    fn,
	output logic [63:0]           r,
	output logic                  ovf
);
	import y86ie_pkg::*;

	always_comb begin
		unique case (fn)
			ALU_ADD: begin
				r   = b + a;
				ovf = ((a[63] ^ r[63]) & (b[63] ^ r[63]));
			end
			ALU_SUB: begin
				r   = b - a;
				ovf = ((a[63] ^ b[63]) & (b[63] ^ r[63]));
			end
			ALU_AND: begin
				r   = a & b;
				ovf = 1'b0;
			end
			default: begin
				r   = a ^ b;
				ovf = 1'b0;
			end
		endcase
	end

endmodule

FILE: src/y86ie_dmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86ie_dmem
// Data memory, one 64-bit word row per eight-byte lane group; a word access
// at an unaligned byte address spans two rows, done one row per cycle.
// ----------------------------------------------------------------------------
module y86ie_dmem #(
	parameter int unsigned ROWS = 1024
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [$clog2(ROWS)-1:0] waddr,
	input  logic [63:0]             wdata,
	input  logic [7:0]              wmask,
	input  logic [$clog2(ROWS)-1:0] raddr,
	output logic [63:0]             rdata
);
	logic [63:0] mem [ROWS];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 8; i++) begin
			if (we && wmask[i]) begin
				mem[waddr][8*i +: 8] <= wdata[8*i +: 8];
			end
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: tb/y86_instruction_execute_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86_instruction_execute_checker
// Watches the request and result channels of the execute core. It keeps its
// own registers, condition codes, run status and byte memory, predicts the
// result of every accepted request and compares the results field by field.
// ----------------------------------------------------------------------------
module y86_instruction_execute_checker #(
	parameter int unsigned MEM_BYTES = y86ie_pkg::MemBytesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [3:0]  mode,
	input  logic [3:0]  func,
	input  logic [3:0]  reg_a,
	input  logic [3:0]  reg_b,
	input  logic [63:0] imm,
	input  logic [15:0] fallthrough_pc,
	input  logic        done,
	input  logic [15:0] next_pc,
	input  logic [1:0]  status,
	input  logic [63:0] write_value,
	input  logic [2:0]  flags,
	output int          errors,
	output int          pending
);
	import y86ie_pkg::*;

	typedef struct packed {
		logic [15:0] npc;
		status_t     st;
		logic [63:0] wv;
		flags_t      cc;
	} outcome_t;

	logic [63:0] regs [RegCount];
	logic [7:0]  mem [MEM_BYTES];
	flags_t      cc;
	status_t     run_st;
	outcome_t    results_due [$];

	assign pending = results_due.size();

	function automatic logic [63:0] reg_read(logic [3:0] r);
		return (r == RegNone) ? 64'd0 : regs[r];
	endfunction

	function automatic logic addr_valid(logic [63:0] a);
		return a <= 64'(MEM_BYTES - WordBytes);
	endfunction

	function automatic int taken(logic [3:0] fn);
		logic lt;
		lt = cc.sf ^ cc.of;
		case (fn)
			FN_ALWAYS: return 1;
			FN_LE:     return int'(lt | cc.zf);
			FN_L:      return int'(lt);
			FN_E:      return int'(cc.zf);
			FN_NE:     return int'(!cc.zf);
			FN_GE:     return int'(!lt);
			FN_G:      return int'(!lt && !cc.zf);
			default:   return -1;
		endcase
	endfunction

	task automatic reg_write(logic [3:0] r, logic [63:0] v);
		if (r != RegNone) regs[r] = v;
	endtask

	function automatic logic [63:0] word_load(logic [63:0] a);
		logic [63:0] v;
		for (int i = 0; i < WordBytes; i++) v[8*i +: 8] = mem[a + i];
		return v;
	endfunction

	task automatic word_store(logic [63:0] a, logic [63:0] v);
		for (int i = 0; i < WordBytes; i++) mem[a + i] = v[8*i +: 8];
	endtask

	task automatic execute_instruction(logic [3:0] m, logic [3:0] fn, logic [3:0] ra,
			logic [3:0] rb, logic [63:0] k, logic [15:0] fpc);
		logic [63:0] a, b, r, sp, addr, wv;
		logic [15:0] npc;
		int c;
		outcome_t o;
		npc = fpc;
		wv = '0;
		if (run_st == ST_AOK) begin
			a = reg_read(ra);
			b = reg_read(rb);
			case (m)
				OP_HALT: run_st = ST_HLT;
				OP_NOP: ;
				OP_CMOV: begin
					c = taken(fn);
					if (c < 0) run_st = ST_INS;
					else if (c == 1) begin
						reg_write(rb, a);
						wv = a;
					end
				end
				OP_IRMOV: begin
					reg_write(rb, k);
					wv = k;
				end
				OP_RMMOV: begin
					addr = b + k;
					if (!addr_valid(addr)) run_st = ST_ADR;
					else begin
						word_store(addr, a);
						wv = a;
					end
				end
				OP_MRMOV: begin
					addr = b + k;
					if (!addr_valid(addr)) run_st = ST_ADR;
					else begin
						r = word_load(addr);
						reg_write(ra, r);
						wv = r;
					end
				end
				OP_ALU: begin
					if (fn > 4'd3) run_st = ST_INS;
					else begin
						case (fn[1:0])
							ALU_ADD: begin
								r = b + a;
								cc.of = (a[63] ^ r[63]) & (b[63] ^ r[63]);
							end
							ALU_SUB: begin
								r = b - a;
								cc.of = (a[63] ^ b[63]) & (b[63] ^ r[63]);
							end
							ALU_AND: begin
								r = a & b;
								cc.of = 1'b0;
							end
							default: begin
								r = a ^ b;
								cc.of = 1'b0;
							end
						endcase
						cc.zf = (r == 64'd0);
						cc.sf = r[63];
						reg_write(rb, r);
						wv = r;
					end
				end
				OP_JUMP: begin
					c = taken(fn);
					if (c < 0) run_st = ST_INS;
					else if (c == 1) npc = k[15:0];
				end
				OP_CALL, OP_PUSH: begin
					sp = regs[RegRsp] - WordBytes;
					if (!addr_valid(sp)) run_st = ST_ADR;
					else begin
						wv = (m == OP_CALL) ? {48'd0, fpc} : a;
						word_store(sp, wv);
						regs[RegRsp] = sp;
						if (m == OP_CALL) npc = k[15:0];
					end
				end
				OP_RET, OP_POP: begin
					sp = regs[RegRsp];
					if (!addr_valid(sp)) run_st = ST_ADR;
					else begin
						r = word_load(sp);
						regs[RegRsp] = sp + WordBytes;
						if (m == OP_RET) begin
							wv = regs[RegRsp];
							npc = r[15:0];
						end else begin
							reg_write(ra, r);
							wv = r;
						end
					end
				end
				OP_IADD: begin
					r = b + k;
					cc.of = (k[63] ^ r[63]) & (b[63] ^ r[63]);
					cc.zf = (r == 64'd0);
					cc.sf = r[63];
					reg_write(rb, r);
					wv = r;
				end
				default: run_st = ST_INS;
			endcase
			if (run_st == ST_ADR || run_st == ST_INS) begin
				npc = fpc;
				wv = '0;
			end
		end
		o.npc = npc;
		o.st = run_st;
		o.wv = wv;
		o.cc = cc;
		results_due = {results_due, o};
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		outcome_t o;
		if (!arst_n) begin
			for (int i = 0; i < RegCount; i++) regs[i] = '0;
			for (int i = 0; i < MEM_BYTES; i++) mem[i] = '0;
			cc = 3'b100;
			run_st = ST_AOK;
			results_due.delete();
		end else begin
			if (done) begin
				if (results_due.size() == 0) report("unexpected result", 64'd1, 64'd0);
				else begin
					o = results_due.pop_front();
					if (next_pc !== o.npc) report("next_pc", 64'(next_pc), 64'(o.npc));
					if (status !== o.st) report("status", 64'(status), 64'(o.st));
					if (write_value !== o.wv) report("write_value", write_value, o.wv);
					if (flags !== o.cc) report("flags", 64'(flags), 64'(o.cc));
				end
			end
			if (start && !busy)
				execute_instruction(mode, func, reg_a, reg_b, imm, fallthrough_pc);
		end
	end

endmodule

FILE: tb/tb_y86_instruction_execute_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_y86_instruction_execute_core
// Drives decoded instructions into the execute core: a directed opening over
// every instruction but halt and field extremes, then random well-formed programs that
// keep the stack and memory addresses valid, and a fault or halt at
// the end followed by requests that must be ignored. The checker predicts.
// ----------------------------------------------------------------------------
module tb_y86_instruction_execute_core;
	import y86ie_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [3:0]  mode;
	logic [3:0]  func;
	logic [3:0]  reg_a;
	logic [3:0]  reg_b;
	logic [63:0] imm;
	logic [15:0] fallthrough_pc;
	logic        done;
	logic [15:0] next_pc;
	logic [1:0]  status;
	logic [63:0] write_value;
	logic [2:0]  flags;
	int          errors;
	int          pending;
	int          cycles;
	int          depth;
	bit          no_gaps;

	y86_instruction_execute_core dut (.*);
	y86_instruction_execute_checker chk (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("y86_instruction_execute_core test failed");
			$finish;
		end
	end

	task automatic issue(logic [3:0] m, logic [3:0] fn, logic [3:0] ra, logic [3:0] rb,
			logic [63:0] k);
		int gap;
		start <= 1'b1;
		mode <= m;
		func <= fn;
		reg_a <= ra;
		reg_b <= rb;
		imm <= k;
		fallthrough_pc <= 16'($urandom);
		do @(posedge clk); while (busy);
		if (!no_gaps && $urandom_range(0, 99) < 29) begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [3:0] dest_reg();
		logic [3:0] r;
		do r = 4'($urandom); while (r == RegRsp);
		return r;
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic random_instruction();
		int pick;
		pick = $urandom_range(0, 12);
		case (pick)
			0: issue(OP_NOP, 4'($urandom), 4'($urandom), 4'($urandom), rand_word());
			1: issue(OP_CMOV, 4'($urandom_range(0, 6)), 4'($urandom), dest_reg(), rand_word());
			2: issue(OP_IRMOV, 4'($urandom), 4'($urandom), dest_reg(), rand_word());
			3: issue(OP_RMMOV, 4'($urandom), 4'($urandom), RegNone,
				64'($urandom_range(0, MemBytesDefault - 8)));
			4: issue(OP_MRMOV, 4'($urandom), dest_reg(), RegRsp,
				64'(signed'($urandom_range(0, 5000)) - 2400));
			5: issue(OP_ALU, 4'($urandom_range(0, 3)), 4'($urandom), dest_reg(), rand_word());
			6: issue(OP_JUMP, 4'($urandom_range(0, 6)), 4'($urandom), 4'($urandom),
				rand_word());
			7, 8: begin
				if (depth < 200) begin
					depth++;
					if (pick == 7) issue(OP_CALL, 4'($urandom), 4'($urandom), 4'($urandom),
						rand_word());
					else issue(OP_PUSH, 4'($urandom), 4'($urandom), 4'($urandom), rand_word());
				end
			end
			9, 10: begin
				if (depth > 0) begin
					depth--;
					if (pick == 9) issue(OP_RET, 4'($urandom), 4'($urandom), 4'($urandom),
						rand_word());
					else issue(OP_POP, 4'($urandom), dest_reg(), 4'($urandom), rand_word());
				end
			end
			11: issue(OP_IADD, 4'($urandom), 4'($urandom), dest_reg(), rand_word());
			default: issue(OP_MRMOV, 4'($urandom), dest_reg(), RegNone,
				64'($urandom_range(0, MemBytesDefault - 8)));
		endcase
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = OP_NOP;
		func = '0;
		reg_a = RegNone;
		reg_b = RegNone;
		imm = '0;
		fallthrough_pc = '0;
		depth = 0;
		no_gaps = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// stack in place, then extremes and every instruction but halt
		issue(OP_IRMOV, FN_ALWAYS, RegNone, RegRsp, 64'd4096);
		issue(OP_IRMOV, 4'hF, RegNone, 4'd0, 64'h7FFF_FFFF_FFFF_FFFF);
		issue(OP_IRMOV, FN_ALWAYS, RegNone, 4'd1, 64'h8000_0000_0000_0000);
		issue(OP_IRMOV, FN_ALWAYS, RegNone, 4'd14, 64'hFFFF_FFFF_FFFF_FFFF);
		issue(OP_IRMOV, FN_ALWAYS, RegNone, RegNone, 64'h1234);
		issue(OP_ALU, 4'(ALU_ADD), 4'd0, 4'd2, 64'd0);
		issue(OP_ALU, 4'(ALU_ADD), 4'd0, 4'd2, 64'd0);
		issue(OP_ALU, 4'(ALU_SUB), 4'd0, 4'd1, 64'd0);
		issue(OP_ALU, 4'(ALU_AND), 4'd14, 4'd3, 64'd0);
		issue(OP_ALU, 4'(ALU_XOR), 4'd14, 4'd14, 64'd0);
		issue(OP_CMOV, FN_E, 4'd0, 4'd5, 64'd0);
		issue(OP_CMOV, FN_NE, 4'd0, 4'd6, 64'd0);
		issue(OP_JUMP, FN_LE, RegNone, RegNone, 64'hFFFF_FFFF_FFFF_ABCD);
		issue(OP_JUMP, FN_G, RegNone, RegNone, 64'h0000_0000_0000_0040);
		issue(OP_RMMOV, 4'hF, 4'd0, RegNone, 64'(MemBytesDefault - 8));
		issue(OP_MRMOV, FN_ALWAYS, 4'd7, 4'd14, 64'(MemBytesDefault - 7));
		issue(OP_RMMOV, FN_ALWAYS, 4'd1, RegNone, 64'd0);
		issue(OP_CALL, FN_ALWAYS, RegNone, RegNone, 64'hFFFF_0000_0000_0100);
		issue(OP_RET, FN_ALWAYS, RegNone, RegNone, 64'd0);
		issue(OP_PUSH, FN_ALWAYS, RegRsp, RegNone, 64'd0);
		issue(OP_POP, FN_ALWAYS, 4'd8, RegNone, 64'd0);
		issue(OP_IADD, FN_ALWAYS, RegNone, 4'd0, 64'd1);
		issue(OP_IADD, 4'hF, RegNone, 4'd9, 64'd0);
		issue(OP_NOP, 4'hF, 4'hF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF);

		for (int n = 0; n < 700; n++) begin
			no_gaps = (n >= 250 && n < 400);
			if (n == 500) begin
				start <= 1'b0;
				while (pending != 0) @(posedge clk);
			end
			random_instruction();
		end

		// one terminal event, then requests that must be ignored
		case ($urandom_range(0, 5))
			0: issue(OP_HALT, 4'($urandom), 4'($urandom), 4'($urandom), rand_word());
			1: issue(4'($urandom_range(13, 15)), 4'($urandom), 4'($urandom), 4'($urandom),
				rand_word());
			2: issue(OP_ALU, 4'($urandom_range(4, 15)), 4'd0, 4'd1, 64'd0);
			3: issue(OP_CMOV, 4'($urandom_range(7, 15)), 4'd0, 4'd1, 64'd0);
			4: issue(OP_JUMP, 4'($urandom_range(7, 15)), RegNone, RegNone, rand_word());
			default: issue(OP_RMMOV, FN_ALWAYS, 4'd0, RegNone,
				64'($urandom_range(MemBytesDefault - 7, 65535)));
		endcase
		repeat (5) random_instruction();
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("y86_instruction_execute_core test passed");
		else
			$display("y86_instruction_execute_core test failed");
		$finish;
	end

endmodule

FILE: sim.f
src/y86ie_pkg.sv
src/y86ie_alu.sv
src/y86ie_dmem.sv
src/y86_instruction_execute_core.sv
tb/y86_instruction_execute_checker.sv
tb/tb_y86_instruction_execute_core.sv
